// File: src/snk_pkg.sv
// Shared types, constants and helpers for the serpentine scan grid generator.
// No dependencies.
package snk_pkg;

	localparam int MAX_GRID       = 1024;
	localparam int STEP_FRAC_BITS = 32;
	localparam int PT_SHIFT       = STEP_FRAC_BITS - 16;
	localparam int ROW_DEN_SHIFT  = 46 - STEP_FRAC_BITS;
	localparam int N_W            = 11;
	localparam int IDX_W          = 10;
	localparam int STEP_W         = 48;
	localparam int DIV_NUM_W      = 64;
	localparam int DIV_DEN_W      = 32;
	localparam int SQRT_IN_W      = 64;
	localparam int SQRT_OUT_W     = 32;

	typedef enum logic [2:0] {
		REG_START_X   = 3'd0,
		REG_START_Y   = 3'd1,
		REG_ROW_END_X = 3'd2,
		REG_ROW_END_Y = 3'd3,
		REG_SIDE_X    = 3'd4,
		REG_SIDE_Y    = 3'd5,
		REG_GRID_PTS  = 3'd6,
		REG_ROW_SPAN  = 3'd7
	} reg_idx_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_PREP,
		OP_CMP1,
		OP_CMP2,
		OP_PERP,
		OP_DIV_GO,
		OP_DIV_SAVE,
		OP_SQ1,
		OP_SQ2,
		OP_SQRT_GO,
		OP_RMUL,
		OP_PMUL,
		OP_PSUM,
		OP_OUT
	} dp_op_t;

	typedef enum logic [2:0] {
		SEL_CX,
		SEL_CY,
		SEL_UX,
		SEL_UY,
		SEL_RX,
		SEL_RY
	} div_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_CMP1,
		ST_CMP2,
		ST_PERP,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_SQ1,
		ST_SQ2,
		ST_SQRT_GO,
		ST_SQRT_WAIT,
		ST_RMUL,
		ST_PMUL,
		ST_PSUM,
		ST_OUT
	} state_t;

	typedef struct packed {
		dp_op_t   op;
		div_sel_t sel;
		logic     axis;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic sqrt_done;
		logic perp_zero;
		logic steps_ready;
		logic out_free;
	} status_t;

	// saturate a magnitude with sign to the signed step range
	function automatic logic signed [STEP_W-1:0] sat_step(input logic neg,
			input logic [DIV_NUM_W-1:0] m);
		logic [DIV_NUM_W-1:0] lim;
		logic [DIV_NUM_W-1:0] negm;
		lim  = DIV_NUM_W'(1) << (STEP_W - 1);
		negm = ~m + DIV_NUM_W'(1);
		if (!neg)
			sat_step = (m >= lim) ? STEP_W'(lim - DIV_NUM_W'(1)) : STEP_W'(m);
		else
			sat_step = (m > lim) ? STEP_W'(lim) : STEP_W'(negm);
	endfunction

endpackage

// File: src/snk_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on snk_pkg.
module snk_div import snk_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIV_NUM_W-1:0] num,
	input  logic [DIV_DEN_W-1:0] den,
	output logic                 done,
	output logic [DIV_NUM_W-1:0] quo
);
	localparam int CNT_W = $clog2(DIV_NUM_W) + 1;

	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_NUM_W-1:0] quo_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_DEN_W:0]   rem_sh;
	logic [DIV_DEN_W:0]   rem_sub;
	logic                 ge;

	assign rem_sh  = {rem_q, quo_q[DIV_NUM_W-1]};
	assign ge      = rem_sh >= {1'b0, den_q};
	assign rem_sub = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DIV_NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
			quo_q <= {quo_q[DIV_NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule

// File: src/snk_isqrt.sv
// Integer square root, one result bit per cycle (floor).
// Depends on snk_pkg.
module snk_isqrt import snk_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [SQRT_IN_W-1:0]  val,
	output logic                  done,
	output logic [SQRT_OUT_W-1:0] root
);
	localparam int CNT_W = $clog2(SQRT_OUT_W) + 1;

	logic [SQRT_IN_W-1:0] v_q;
	logic [SQRT_IN_W-1:0] r_q;
	logic [SQRT_IN_W-1:0] bit_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [SQRT_IN_W-1:0] trial;

	assign trial = r_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(SQRT_OUT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= val;
			r_q   <= '0;
			bit_q <= SQRT_IN_W'(1) << (SQRT_IN_W - 2);
		end else if (busy_q) begin
			if (v_q >= trial) begin
				v_q <= v_q - trial;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = r_q[SQRT_OUT_W-1:0];
endmodule

// File: src/snk_dp.sv
// Datapath: configuration registers, step setup arithmetic, point evaluation
// and output register. Depends on snk_pkg, snk_div and snk_isqrt.
module snk_dp import snk_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  cmd_t               cmd,
	output status_t            status,
	input  logic               out_ready,
	output logic               out_valid,
	output logic signed [31:0] point_x,
	output logic signed [31:0] point_y,
	output logic [IDX_W-1:0]   grid_row,
	output logic [IDX_W-1:0]   grid_column,
	output logic               last_point
);
	localparam int PA_W = STEP_W + IDX_W + 1;

	logic signed [31:0] start_x_q, start_y_q, end_x_q, end_y_q, side_x_q, side_y_q;
	logic [N_W-1:0]     grid_pts_q;
	logic [30:0]        span_q;

	logic [N_W-1:0]     n_q;
	logic [IDX_W-1:0]   row_q, col_q;
	logic               steps_ready_q;
	logic signed [32:0] dx_q, dy_q, sdx_q, sdy_q;
	logic signed [65:0] prod1_q, prod2_q;
	logic [32:0]        mx_q, my_q;
	logic               pnegx_q, pnegy_q, perp_zero_q;
	logic [62:0]        sq_q;
	logic [30:0]        ux_q, uy_q;
	logic [61:0]        prod_r_q;
	logic signed [STEP_W-1:0] csx_q, csy_q, rsx_q, rsy_q;
	logic signed [PA_W-1:0]   pa_q, pb_q;
	logic signed [31:0] pt_x_q, pt_y_q;

	logic               out_valid_q;
	logic signed [31:0] out_x_q, out_y_q;
	logic [IDX_W-1:0]   out_row_q, out_col_q;
	logic               out_last_q;

	logic [N_W-1:0]     n_clamp;
	logic [32:0]        absdx, absdy, m_max;
	logic [30:0]        mxs, mys;
	logic [IDX_W-1:0]   nm1, jj;
	logic               flip, last;
	logic [DIV_NUM_W-1:0] div_num;
	logic [DIV_DEN_W-1:0] div_den;
	logic [DIV_NUM_W-1:0] quo;
	logic                 div_done;
	logic [SQRT_OUT_W-1:0] norm;
	logic                  sqrt_done;
	logic signed [63:0]   acc;
	logic signed [47:0]   acc_sh;
	logic signed [31:0]   pt_sat;
	logic signed [31:0]   st_sel;
	logic [N_W-1:0]       col_nx, row_nx;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q  <= '0;
			start_y_q  <= '0;
			end_x_q    <= 32'sd65536;
			end_y_q    <= '0;
			side_x_q   <= '0;
			side_y_q   <= 32'sd65536;
			grid_pts_q <= N_W'(2);
			span_q     <= 31'd65536;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_START_X:   start_x_q  <= cfg_data;
				REG_START_Y:   start_y_q  <= cfg_data;
				REG_ROW_END_X: end_x_q    <= cfg_data;
				REG_ROW_END_Y: end_y_q    <= cfg_data;
				REG_SIDE_X:    side_x_q   <= cfg_data;
				REG_SIDE_Y:    side_y_q   <= cfg_data;
				REG_GRID_PTS:  grid_pts_q <= cfg_data[N_W-1:0];
				REG_ROW_SPAN:  span_q     <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (grid_pts_q < N_W'(2))
			n_clamp = N_W'(2);
		else if (grid_pts_q > N_W'(MAX_GRID))
			n_clamp = N_W'(MAX_GRID);
		else
			n_clamp = grid_pts_q;
	end

	assign absdx = dx_q[32] ? 33'(-dx_q) : 33'(dx_q);
	assign absdy = dy_q[32] ? 33'(-dy_q) : 33'(dy_q);
	assign flip  = prod1_q < prod2_q;
	assign m_max = (mx_q > my_q) ? mx_q : my_q;

	// bring the larger magnitude below 2^31, truncating
	always_comb begin
		if (m_max[32]) begin
			mxs = mx_q[32:2];
			mys = my_q[32:2];
		end else if (m_max[31]) begin
			mxs = mx_q[31:1];
			mys = my_q[31:1];
		end else begin
			mxs = mx_q[30:0];
			mys = my_q[30:0];
		end
	end

	assign nm1 = IDX_W'(n_q - N_W'(1));

	always_comb begin
		div_num = '0;
		div_den = '0;
		case (cmd.sel)
			SEL_CX: begin
				div_num = (DIV_NUM_W'(absdx) << PT_SHIFT) + DIV_NUM_W'(nm1 >> 1);
				div_den = DIV_DEN_W'(nm1);
			end
			SEL_CY: begin
				div_num = (DIV_NUM_W'(absdy) << PT_SHIFT) + DIV_NUM_W'(nm1 >> 1);
				div_den = DIV_DEN_W'(nm1);
			end
			SEL_UX: begin
				div_num = (DIV_NUM_W'(mxs) << 30) + DIV_NUM_W'(norm >> 1);
				div_den = norm;
			end
			SEL_UY: begin
				div_num = (DIV_NUM_W'(mys) << 30) + DIV_NUM_W'(norm >> 1);
				div_den = norm;
			end
			SEL_RX, SEL_RY: begin
				div_num = DIV_NUM_W'(prod_r_q)
					+ (DIV_NUM_W'(nm1) << (ROW_DEN_SHIFT - 1));
				div_den = DIV_DEN_W'(nm1) << ROW_DEN_SHIFT;
			end
			default: ;
		endcase
	end

	snk_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.op == OP_DIV_GO),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (quo)
	);

	snk_isqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.op == OP_SQRT_GO),
		.val    (SQRT_IN_W'(sq_q)),
		.done   (sqrt_done),
		.root   (norm)
	);

	// serpentine: odd rows walk the inner index backwards
	assign jj   = row_q[0] ? IDX_W'(nm1 - col_q) : col_q;
	assign last = (row_q == nm1) && (col_q == nm1);

	assign st_sel = cmd.axis ? start_y_q : start_x_q;
	assign acc    = (64'(st_sel) <<< PT_SHIFT) + 64'(pa_q) + 64'(pb_q)
		+ (64'sd1 <<< (PT_SHIFT - 1));
	assign acc_sh = 48'(acc >>> PT_SHIFT);

	always_comb begin
		if (acc_sh > 48'sd2147483647)
			pt_sat = 32'sh7fffffff;
		else if (acc_sh < -48'sd2147483648)
			pt_sat = 32'sh80000000;
		else
			pt_sat = acc_sh[31:0];
	end

	assign col_nx = N_W'(col_q) + N_W'(1);
	assign row_nx = N_W'(row_q) + N_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_ready_q <= 1'b0;
			n_q           <= N_W'(2);
			row_q         <= '0;
			col_q         <= '0;
		end else begin
			if (cmd.op == OP_PREP) begin
				steps_ready_q <= 1'b1;
				n_q           <= n_clamp;
				row_q         <= '0;
				col_q         <= '0;
			end else if (cmd.op == OP_OUT) begin
				if (col_nx >= n_q) begin
					col_q <= '0;
					row_q <= (row_nx >= n_q) ? '0 : IDX_W'(row_nx);
				end else begin
					col_q <= IDX_W'(col_nx);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_PREP: begin
				dx_q  <= 33'(end_x_q) - 33'(start_x_q);
				dy_q  <= 33'(end_y_q) - 33'(start_y_q);
				sdx_q <= 33'(side_x_q) - 33'(start_x_q);
				sdy_q <= 33'(side_y_q) - 33'(start_y_q);
			end
			OP_CMP1: prod1_q <= dx_q * sdy_q;
			OP_CMP2: prod2_q <= dy_q * sdx_q;
			OP_PERP: begin
				// perpendicular is (-dy, dx), negated when flip
				mx_q        <= absdy;
				my_q        <= absdx;
				pnegx_q     <= flip ? dy_q[32] : (dy_q > 33'sd0);
				pnegy_q     <= flip ? (dx_q > 33'sd0) : dx_q[32];
				perp_zero_q <= (dx_q == 33'sd0) && (dy_q == 33'sd0);
				rsx_q       <= '0;
				rsy_q       <= '0;
			end
			OP_SQ1: sq_q <= 63'(mxs) * 63'(mxs);
			OP_SQ2: sq_q <= sq_q + 63'(mys) * 63'(mys);
			OP_RMUL: prod_r_q <= 62'(cmd.sel == SEL_RY ? uy_q : ux_q) * 62'(span_q);
			OP_DIV_SAVE: begin
				case (cmd.sel)
					SEL_CX: csx_q <= sat_step(dx_q[32], quo);
					SEL_CY: csy_q <= sat_step(dy_q[32], quo);
					SEL_UX: ux_q  <= quo[30:0];
					SEL_UY: uy_q  <= quo[30:0];
					SEL_RX: rsx_q <= sat_step(pnegx_q, quo);
					SEL_RY: rsy_q <= sat_step(pnegy_q, quo);
					default: ;
				endcase
			end
			OP_PMUL: begin
				pa_q <= PA_W'(cmd.axis ? csy_q : csx_q) * $signed({1'b0, row_q});
				pb_q <= PA_W'(cmd.axis ? rsy_q : rsx_q) * $signed({1'b0, jj});
			end
			OP_PSUM: begin
				if (cmd.axis)
					pt_y_q <= pt_sat;
				else
					pt_x_q <= pt_sat;
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.op == OP_OUT)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_OUT) begin
			out_x_q    <= pt_x_q;
			out_y_q    <= pt_y_q;
			out_row_q  <= row_q;
			out_col_q  <= col_q;
			out_last_q <= last;
		end
	end

	assign status.div_done    = div_done;
	assign status.sqrt_done   = sqrt_done;
	assign status.perp_zero   = perp_zero_q;
	assign status.steps_ready = steps_ready_q;
	assign status.out_free    = !out_valid_q || out_ready;

	assign out_valid   = out_valid_q;
	assign point_x     = out_x_q;
	assign point_y     = out_y_q;
	assign grid_row    = out_row_q;
	assign grid_column = out_col_q;
	assign last_point  = out_last_q;
endmodule

// File: src/snk_ctrl.sv
// Controller: sequences step setup and point evaluation in the datapath.
// Depends on snk_pkg.
module snk_ctrl import snk_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    restart,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd
);
	state_t   state_q, state_d;
	div_sel_t sel_q, sel_d;
	logic     axis_q, axis_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_q   <= SEL_CX;
			axis_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
			axis_q  <= axis_d;
		end
	end

	always_comb begin
		state_d = state_q;
		sel_d   = sel_q;
		axis_d  = axis_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					axis_d = 1'b0;
					if (restart || !status.steps_ready)
						state_d = ST_PREP;
					else
						state_d = ST_PMUL;
				end
			end
			ST_PREP: state_d = ST_CMP1;
			ST_CMP1: state_d = ST_CMP2;
			ST_CMP2: state_d = ST_PERP;
			ST_PERP: begin
				sel_d   = SEL_CX;
				state_d = ST_DIV_GO;
			end
			ST_DIV_GO: state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (status.div_done) begin
					case (sel_q)
						SEL_CX: begin
							sel_d   = SEL_CY;
							state_d = ST_DIV_GO;
						end
						SEL_CY: state_d = status.perp_zero ? ST_PMUL : ST_SQ1;
						SEL_UX: begin
							sel_d   = SEL_UY;
							state_d = ST_DIV_GO;
						end
						SEL_UY: begin
							sel_d   = SEL_RX;
							state_d = ST_RMUL;
						end
						SEL_RX: begin
							sel_d   = SEL_RY;
							state_d = ST_RMUL;
						end
						default: state_d = ST_PMUL;
					endcase
				end
			end
			ST_SQ1: state_d = ST_SQ2;
			ST_SQ2: state_d = ST_SQRT_GO;
			ST_SQRT_GO: state_d = ST_SQRT_WAIT;
			ST_SQRT_WAIT: begin
				if (status.sqrt_done) begin
					sel_d   = SEL_UX;
					state_d = ST_DIV_GO;
				end
			end
			ST_RMUL: state_d = ST_DIV_GO;
			ST_PMUL: state_d = ST_PSUM;
			ST_PSUM: begin
				if (axis_q)
					state_d = ST_OUT;
				else begin
					axis_d  = 1'b1;
					state_d = ST_PMUL;
				end
			end
			ST_OUT: if (status.out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.op   = OP_NONE;
		cmd.sel  = sel_q;
		cmd.axis = axis_q;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE:      in_ready = 1'b1;
			ST_PREP:      cmd.op = OP_PREP;
			ST_CMP1:      cmd.op = OP_CMP1;
			ST_CMP2:      cmd.op = OP_CMP2;
			ST_PERP:      cmd.op = OP_PERP;
			ST_DIV_GO:    cmd.op = OP_DIV_GO;
			ST_DIV_WAIT:  cmd.op = status.div_done ? OP_DIV_SAVE : OP_NONE;
			ST_SQ1:       cmd.op = OP_SQ1;
			ST_SQ2:       cmd.op = OP_SQ2;
			ST_SQRT_GO:   cmd.op = OP_SQRT_GO;
			ST_RMUL:      cmd.op = OP_RMUL;
			ST_PMUL:      cmd.op = OP_PMUL;
			ST_PSUM:      cmd.op = OP_PSUM;
			ST_OUT:       cmd.op = status.out_free ? OP_OUT : OP_NONE;
			default:      cmd.op = OP_NONE;
		endcase
	end
endmodule

// File: src/snake_grid_scan_generator.sv
// Serpentine scan grid generator, Q16.16, top level.
// Plain request: x then y pass through multiply and sum, then the output register;
// one request at a time. Restart or first request: up to six divides and a square
// root in the setup sequencer run first (fewer when the row vector is zero).
// The next request is taken while a result waits in the output register.
// Reset (arst_n low) restores register defaults and forces setup on first request.
module snake_grid_scan_generator import snk_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               restart,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] point_x,
	output logic signed [31:0] point_y,
	output logic [9:0]         grid_row,
	output logic [9:0]         grid_column,
	output logic               last_point
);
	cmd_t    cmd;
	status_t status;

	snk_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.restart  (restart),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	snk_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cmd         (cmd),
		.status      (status),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.point_x     (point_x),
		.point_y     (point_y),
		.grid_row    (grid_row),
		.grid_column (grid_column),
		.last_point  (last_point)
	);
endmodule
